// ----- design/iorm_pkg.sv -----
// package for the interval offset range map
// holds payload structs, command codes and shared constants; no dependencies
`default_nettype none
package iorm_pkg;
	localparam int unsigned TableDepthDefault = 64;
	localparam int unsigned ValW = 48;
	localparam int unsigned KeyW = 49;
	localparam int unsigned OffW = 50;
	localparam int unsigned CountW = 7;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]      cmd;
		logic [ValW-1:0] dest_start;
		logic [ValW-1:0] src_start;
		logic [ValW-1:0] range_length;
		logic [ValW-1:0] query_value;
	} in_item_t;

	typedef struct packed {
		logic signed [OffW-1:0] mapped_value;
		logic                   status;
		logic [CountW-1:0]      entry_count;
	} out_item_t;
endpackage
`default_nettype wire

// ----- design/iorm_ram.sv -----
// generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none
module iorm_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ----- design/interval_offset_range_map.sv -----
// interval offset range map, top level
// depends on iorm_pkg and iorm_ram
//
// usage: drive in_item and raise start while busy is low; the beat is taken
// at that edge and busy rises until the result is shown. the result appears
// on out_item for exactly one cycle with done high; the receiver cannot stall
// and must take it then.
// keys and offsets live in one ram (key and offset packed per entry), registered
// read, single port. lookup and add walk the table linearly:
//   clear, cmd 3 : no table walk; straight to the result
//   lookup       : scan until first key above the value
//   add range    : two insertions, each a scan, a check step and, for a new
//                  key, a shift walk from the top entry down to the insert
//                  point (a read and a write per moved entry) and a write step
// throughput is set by the single ram port and the table fill; no new item is taken while busy.
// reset clears the key count and control; the ram is not cleared, only
// entries below the count are ever read.
// a full table drops a new key and sets status; overwrites always succeed.
`default_nettype none
module interval_offset_range_map #(
	parameter int unsigned TABLE_DEPTH = iorm_pkg::TableDepthDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire iorm_pkg::in_item_t  in_item,
	output logic                     busy,
	output logic                     done,
	output iorm_pkg::out_item_t      out_item
);
	import iorm_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned EW = KeyW + OffW;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SCAN   = 7'b0000010,
		ST_CHECK  = 7'b0000100,
		ST_SHRD   = 7'b0001000,
		ST_SHWR   = 7'b0010000,
		ST_PUT    = 7'b0100000,
		ST_RESULT = 7'b1000000
	} state_t;

	state_t             state_q;
	in_item_t           item_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;      // scan index / shift pointer
	logic [CW-1:0]      pos_q;      // insert position
	logic               phase_q;    // 0 start key, 1 end key
	logic               status_q;
	logic               hit_q;      // a key at or below query seen
	logic [OffW-1:0]    off_q;      // offset of best key so far
	logic [KeyW-1:0]    key_q;
	logic [OffW-1:0]    newoff_q;
	logic               rd_pend_q;  // ram data valid this cycle
	logic [CW-1:0]      rd_idx_q;

	logic               ram_we;
	logic [AW-1:0]      ram_addr;
	logic [EW-1:0]      ram_wdata;
	logic [EW-1:0]      ram_rdata;
	logic [KeyW-1:0]    rd_key;
	logic [OffW-1:0]    rd_off;

	assign rd_key = ram_rdata[EW-1:OffW];
	assign rd_off = ram_rdata[OffW-1:0];

	iorm_ram #(.Width(EW), .Depth(TABLE_DEPTH)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// ram port control
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = idx_q[AW-1:0];
		ram_wdata = {key_q, newoff_q};
		unique case (state_q)
			ST_SHRD: ram_addr = AW'(idx_q - CW'(1));
			ST_SHWR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			ST_PUT: begin
				ram_we   = 1'b1;
				ram_addr = pos_q[AW-1:0];
			end
			default: ;
		endcase
	end

	logic [ValW:0] end_key;
	assign end_key = {1'b0, item_q.src_start} + {1'b0, item_q.range_length};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			done      <= 1'b0;
			rd_pend_q <= 1'b0;
			item_q    <= '0;
			idx_q     <= '0;
			pos_q     <= '0;
			phase_q   <= 1'b0;
			status_q  <= 1'b0;
			hit_q     <= 1'b0;
			off_q     <= '0;
			key_q     <= '0;
			newoff_q  <= '0;
			rd_idx_q  <= '0;
		end else begin
			done      <= 1'b0;
			rd_pend_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (start) begin
					item_q   <= in_item;
					status_q <= 1'b0;
					hit_q    <= 1'b0;
					idx_q    <= '0;
					phase_q  <= 1'b0;
					key_q    <= {1'b0, in_item.src_start};
					newoff_q <= OffW'($signed({2'b0, in_item.dest_start})
						- $signed({2'b0, in_item.src_start}));
					unique case (in_item.cmd) inside
						CMD_CLEAR: begin
							count_q <= '0;
							state_q <= ST_RESULT;
						end
						CMD_ADD, CMD_LOOKUP: state_q <= ST_SCAN;
						default: state_q <= ST_RESULT;
					endcase
				end
				ST_SCAN: begin
					// issue read of idx_q if in range, judge last read
					if (rd_pend_q) begin
						if (item_q.cmd == CMD_LOOKUP) begin
							if (rd_key <= {1'b0, item_q.query_value}) begin
								hit_q <= 1'b1;
								off_q <= rd_off;
							end else begin
								state_q <= ST_RESULT;
							end
						end else if (rd_key >= key_q) begin
							pos_q   <= rd_idx_q;
							hit_q   <= (rd_key == key_q);
							state_q <= ST_CHECK;
						end
					end
					if (state_q == ST_SCAN && !(rd_pend_q && ((item_q.cmd == CMD_LOOKUP)
						? (rd_key > {1'b0, item_q.query_value}) : (rd_key >= key_q)))) begin
						if (idx_q < count_q) begin
							rd_pend_q <= 1'b1;
							rd_idx_q  <= idx_q;
							idx_q     <= idx_q + CW'(1);
						end else if (item_q.cmd == CMD_LOOKUP) begin
							state_q <= ST_RESULT;
						end else begin
							pos_q   <= count_q;
							hit_q   <= 1'b0;
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (hit_q) begin
						state_q <= (phase_q == 1'b0) ? ST_PUT : ST_RESULT;
						if (phase_q) state_q <= ST_RESULT;
					end else if (count_q >= CW'(TABLE_DEPTH)) begin
						status_q <= 1'b1;
						state_q  <= ST_RESULT;
					end else begin
						idx_q   <= count_q;
						state_q <= (count_q > pos_q) ? ST_SHRD : ST_PUT;
					end
					if (phase_q == 1'b0 && !(hit_q || count_q < CW'(TABLE_DEPTH))) begin
						// start key dropped: still try the end key
						state_q <= ST_RESULT;
					end
				end
				ST_SHRD: state_q <= ST_SHWR;
				ST_SHWR: begin
					idx_q   <= idx_q - CW'(1);
					state_q <= (idx_q - CW'(1) > pos_q) ? ST_SHRD : ST_PUT;
				end
				ST_PUT: begin
					if (!hit_q) count_q <= count_q + CW'(1);
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (item_q.cmd == CMD_ADD && phase_q == 1'b0) begin
						// second insertion: end key, offset zero, no overwrite
						phase_q  <= 1'b1;
						key_q    <= KeyW'(end_key);
						newoff_q <= '0;
						idx_q    <= '0;
						hit_q    <= 1'b0;
						state_q  <= ST_SCAN;
					end else begin
						done    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic [OffW-1:0] sum;
	assign sum = {2'b0, item_q.query_value} + (hit_q ? off_q : '0);

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT) begin
			out_item.mapped_value <= (item_q.cmd == CMD_LOOKUP) ? $signed(sum) : '0;
			out_item.status       <= status_q;
			out_item.entry_count  <= CountW'(count_q);
		end
	end

	assign busy = (state_q != ST_IDLE);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH)) else $error("key count above depth");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result shown twice");
	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy with result out");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == '0 || count_q == $past(count_q) + CW'(1)))
		else $error("key count jumped");
endmodule
`default_nettype wire
